>>> rtl/wms_pkg.sv
// Shared types, widths and helpers for the window median selector.
package wms_pkg;

	localparam int ROW_PIX = 7;
	localparam int PIX_W = 8;
	localparam int ROW_W = ROW_PIX * PIX_W;
	localparam int WIN_W = 3;
	localparam int RANK_MAX_W = 6;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [WIN_W-1:0] win_size_t;

	localparam win_size_t WIN_SIZE_RESET = 3'd3;

	// Load enables handed from the top level to every rank lane
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
	} lane_ctl_t;

	// Rank of the median within a k by k window: k*k/2
	function automatic logic [RANK_MAX_W-1:0] median_rank(input win_size_t k);
		logic [RANK_MAX_W-1:0] sq;
		sq = RANK_MAX_W'(k) * RANK_MAX_W'(k);
		return sq >> 1;
	endfunction

endpackage

>>> rtl/wms_if.sv
// Handshake channels for window beats and result beats.
interface wms_win_if;
	import wms_pkg::*;
	logic valid;
	logic ready;
	row_t window_row_0;
	row_t window_row_1;
	row_t window_row_2;
	row_t window_row_3;
	row_t window_row_4;
	row_t window_row_5;
	row_t window_row_6;

	modport source (
		output valid, window_row_0, window_row_1, window_row_2, window_row_3,
		window_row_4, window_row_5, window_row_6,
		input ready
	);
	modport sink (
		input valid, window_row_0, window_row_1, window_row_2, window_row_3,
		window_row_4, window_row_5, window_row_6,
		output ready
	);
endinterface

interface wms_res_if;
	import wms_pkg::*;
	logic valid;
	logic ready;
	pixel_t median_value;
	logic size_error;

	modport source (output valid, median_value, size_error, input ready);
	modport sink (input valid, median_value, size_error, output ready);
endinterface

>>> rtl/wms_rank_lane.sv
// One lane: ranks the pixels of one window row against the whole window.
module wms_rank_lane #(
	parameter int MAX_WINDOW = 7,
	parameter int LANE = 0
) (
	input logic clk,
	input wms_pkg::lane_ctl_t ctl,
	input wms_pkg::pixel_t pix_s1 [MAX_WINDOW*MAX_WINDOW],
	input logic [MAX_WINDOW*MAX_WINDOW-1:0] act_s1,
	input logic [$clog2(MAX_WINDOW*MAX_WINDOW)-1:0] tgt_s2,
	output logic [MAX_WINDOW-1:0] hit_s3,
	output wms_pkg::pixel_t pix_s3 [MAX_WINDOW]
);
	import wms_pkg::*;

	localparam int N = MAX_WINDOW * MAX_WINDOW;
	localparam int RANK_W = $clog2(N);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_pix
		localparam int OWN = LANE * MAX_WINDOW + gi;

		logic [MAX_WINDOW-1:0] lt [MAX_WINDOW];
		logic [CNT_W-1:0] part_s2 [MAX_WINDOW];
		pixel_t pix_s2;
		logic act_s2;
		logic [RANK_W-1:0] rank;

		// Pixel j sits below this one if smaller, or equal and earlier in the window
		for (genvar gr = 0; gr < MAX_WINDOW; gr++) begin : g_row
			for (genvar gc = 0; gc < MAX_WINDOW; gc++) begin : g_col
				localparam int J = gr * MAX_WINDOW + gc;
				localparam bit EARLIER = (J < OWN);
				assign lt[gr][gc] = act_s1[J] && ((pix_s1[J] < pix_s1[OWN]) ||
					((pix_s1[J] == pix_s1[OWN]) && EARLIER));
			end

			always_ff @(posedge clk) begin
				if (ctl.adv_s2) begin
					part_s2[gr] <= CNT_W'($countones(lt[gr]));
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv_s2) begin
				pix_s2 <= pix_s1[OWN];
				act_s2 <= act_s1[OWN];
			end
		end

		always_comb begin
			rank = '0;
			for (int k = 0; k < MAX_WINDOW; k++) begin
				rank = rank + RANK_W'(part_s2[k]);
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv_s3) begin
				hit_s3[gi] <= act_s2 && (rank == tgt_s2);
				pix_s3[gi] <= pix_s2;
			end
		end
	end

endmodule

>>> rtl/wms_merge.sv
// Merge stage: picks the single pixel whose rank matched across all lanes.
module wms_merge #(
	parameter int MAX_WINDOW = 7
) (
	input logic clk,
	input logic adv_s4,
	input logic [MAX_WINDOW-1:0] hit_s3 [MAX_WINDOW],
	input wms_pkg::pixel_t pix_s3 [MAX_WINDOW][MAX_WINDOW],
	input logic err_s3,
	output wms_pkg::pixel_t median_s4,
	output logic err_s4
);
	import wms_pkg::*;

	pixel_t pick;

	// At most one hit is set, so an OR of the gated pixels selects it
	always_comb begin
		pick = '0;
		for (int l = 0; l < MAX_WINDOW; l++) begin
			for (int p = 0; p < MAX_WINDOW; p++) begin
				pick = pick | (hit_s3[l][p] ? pix_s3[l][p] : '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			median_s4 <= pick;
			err_s4 <= err_s3;
		end
	end

endmodule

>>> rtl/window_median_select_core.sv
// Top level of the square-window median selector.
// Takes one pixel window of up to 7x7 8-bit pixels per beat and returns its median,
// the pixel of rank k*k/2 with k the programmed window size (odd, 1..MAX_WINDOW).
// Throughput is one window per clock while ready is high; an accepted window beat
// passes through stages 1 to 4 to its result beat. Each of MAX_WINDOW lanes ranks
// the pixels of one row against every pixel of the window (one comparator per pixel
// pair), the per-row counts are added in the next stage, and a merge stage selects
// the one pixel whose rank equals the median rank. An even or oversize window size
// yields median 0 with size_error set. The four stages advance independently, so a
// window beat is still taken while a finished result waits; ready falls only when
// all four stages hold data and the result is not being taken. Write window_size
// only while no beat is in flight.
module window_median_select_core #(
	parameter int MAX_WINDOW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input wms_pkg::win_size_t cfg_wdata,
	wms_win_if.sink pixels,
	wms_res_if.source result
);
	import wms_pkg::*;

	localparam int N = MAX_WINDOW * MAX_WINDOW;
	localparam int RANK_W = $clog2(N);

	// Configuration register
	win_size_t window_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_SIZE_RESET;
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
		end
	end

	// Pipeline control: each stage advances when it is empty or the next one advances
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	lane_ctl_t lane_ctl;

	assign en4 = !v_s4 || result.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixels.ready = en1;
	assign lane_ctl.adv_s2 = en2;
	assign lane_ctl.adv_s3 = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixels.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Unpack the window rows into a flat pixel list, row major
	row_t rows [ROW_PIX];
	pixel_t pix_in [N];
	logic [N-1:0] act_in;
	logic err_in;

	assign rows[0] = pixels.window_row_0;
	assign rows[1] = pixels.window_row_1;
	assign rows[2] = pixels.window_row_2;
	assign rows[3] = pixels.window_row_3;
	assign rows[4] = pixels.window_row_4;
	assign rows[5] = pixels.window_row_5;
	assign rows[6] = pixels.window_row_6;

	// Even sizes and sizes beyond the lane count are rejected
	assign err_in = !window_size_q[0] || (window_size_q > WIN_W'(MAX_WINDOW));

	for (genvar gr = 0; gr < MAX_WINDOW; gr++) begin : g_unpack_row
		for (genvar gc = 0; gc < MAX_WINDOW; gc++) begin : g_unpack_col
			assign pix_in[gr*MAX_WINDOW+gc] = rows[gr][gc*PIX_W +: PIX_W];
			// Drop pixels outside the k by k corner; drop all on a size error
			assign act_in[gr*MAX_WINDOW+gc] = !err_in &&
				(WIN_W'(gr) < window_size_q) && (WIN_W'(gc) < window_size_q);
		end
	end

	// Stage 1: hold the window, its active mask and the median rank
	pixel_t pix_s1 [N];
	logic [N-1:0] act_s1;
	logic [RANK_W-1:0] tgt_s1, tgt_s2;
	logic err_s1, err_s2, err_s3;

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1 <= pix_in;
			act_s1 <= act_in;
			tgt_s1 <= RANK_W'(median_rank(window_size_q));
			err_s1 <= err_in;
		end
		if (en2) begin
			tgt_s2 <= tgt_s1;
			err_s2 <= err_s1;
		end
		if (en3) begin
			err_s3 <= err_s2;
		end
	end

	// Stages 2 and 3: one rank lane per window row
	logic [MAX_WINDOW-1:0] lane_hit_s3 [MAX_WINDOW];
	pixel_t lane_pix_s3 [MAX_WINDOW][MAX_WINDOW];
	logic [N-1:0] hit_s3;

	for (genvar gl = 0; gl < MAX_WINDOW; gl++) begin : g_lane
		wms_rank_lane #(
			.MAX_WINDOW(MAX_WINDOW),
			.LANE(gl)
		) u_lane (
			.clk(clk),
			.ctl(lane_ctl),
			.pix_s1(pix_s1),
			.act_s1(act_s1),
			.tgt_s2(tgt_s2),
			.hit_s3(lane_hit_s3[gl]),
			.pix_s3(lane_pix_s3[gl])
		);
		assign hit_s3[gl*MAX_WINDOW +: MAX_WINDOW] = lane_hit_s3[gl];
	end

	// Stage 4: merge the lanes into the result register
	pixel_t median_s4;
	logic err_s4;

	wms_merge #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_merge (
		.clk(clk),
		.adv_s4(en4),
		.hit_s3(lane_hit_s3),
		.pix_s3(lane_pix_s3),
		.err_s3(err_s3),
		.median_s4(median_s4),
		.err_s4(err_s4)
	);

	assign result.valid = v_s4;
	assign result.median_value = median_s4;
	assign result.size_error = err_s4;

`ifndef SYNTHESIS
	// Tie-broken ranks are unique, so a good window has exactly one median hit
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !err_s3 |-> $onehot(hit_s3))
		else $error("median hit not unique");

	a_no_hit_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && err_s3 |-> hit_s3 == '0)
		else $error("median hit despite size error");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.size_error |-> result.median_value == '0)
		else $error("nonzero median with size error");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && !result.ready)
		else $error("window beat refused with room in the pipeline");

	a_mask_error: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> err_s1 == (act_s1 == '0))
		else $error("active mask disagrees with size error");
`endif

endmodule

>>> sim/wms_median_checker.sv
// Checker for the window median selector: predicts each result beat and compares it.
module wms_median_checker #(
	parameter int MAX_WINDOW = 7,
	parameter int MAX_REPORTS = 30
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input wms_pkg::win_size_t cfg_wdata,
	wms_win_if win,
	wms_res_if res,
	output int unsigned fail_count,
	output int unsigned in_flight
);
	import wms_pkg::*;

	typedef row_t [ROW_PIX-1:0] window_t;

	typedef struct packed {
		pixel_t median;
		logic size_error;
	} median_exp_t;

	win_size_t size_q;
	median_exp_t expected_medians [$];

	// Histogram select: the value where the running count first passes rank k*k/2.
	function automatic median_exp_t predict_median(input window_t w, input win_size_t k);
		int unsigned hist [256];
		int unsigned side;
		int unsigned rank;
		int unsigned seen;
		median_exp_t e;
		e.median = '0;
		e.size_error = 1'b0;
		side = int'(k);
		if (k[0] == 1'b0 || side > MAX_WINDOW || side > ROW_PIX) begin
			e.size_error = 1'b1;
			return e;
		end
		foreach (hist[v])
			hist[v] = 0;
		for (int r = 0; r < side; r++)
			for (int c = 0; c < side; c++)
				hist[w[r][c*PIX_W +: PIX_W]]++;
		rank = (side * side) / 2;
		seen = 0;
		for (int v = 0; v < 256; v++) begin
			seen += hist[v];
			if (seen > rank) begin
				e.median = pixel_t'(v);
				break;
			end
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		median_exp_t want;
		window_t rows;
		int unsigned errs;
		if (!arst_n) begin
			size_q <= WIN_SIZE_RESET;
			expected_medians.delete();
			fail_count <= 0;
			in_flight <= 0;
		end else begin
			errs = 0;
			// retire the oldest expectation before queueing this edge's window
			if (res.valid && res.ready) begin
				if (expected_medians.size() == 0) begin
					errs++;
					if (fail_count < MAX_REPORTS)
						$display("%0t: result beat with nothing expected: median %02h size_error %b",
							$time, res.median_value, res.size_error);
				end else begin
					want = expected_medians.pop_front();
					if (res.median_value !== want.median) begin
						errs++;
						if (fail_count < MAX_REPORTS)
							$display("%0t: median_value mismatch: expected %02h actual %02h",
								$time, want.median, res.median_value);
					end
					if (res.size_error !== want.size_error) begin
						errs++;
						if (fail_count < MAX_REPORTS)
							$display("%0t: size_error mismatch: expected %b actual %b",
								$time, want.size_error, res.size_error);
					end
				end
			end
			if (win.valid && win.ready) begin
				rows = {win.window_row_6, win.window_row_5, win.window_row_4, win.window_row_3,
					win.window_row_2, win.window_row_1, win.window_row_0};
				expected_medians.push_back(predict_median(rows, size_q));
			end
			if (cfg_we)
				size_q <= cfg_wdata;
			fail_count <= fail_count + errs;
			in_flight <= expected_medians.size();
		end
	end

endmodule

>>> sim/tb_window_median_select_core.sv
// Testbench top for window_median_select_core: stimulus, result sink and verdict.
module tb_window_median_select_core;
	import wms_pkg::*;

	localparam int MAX_WINDOW = 7;
	localparam int RANDOM_WINDOWS = 2000;
	// last stretch of the run goes with no idling on either side
	localparam int CALM_TAIL = 200;
	// result side holds off this long once, so the four stages fill and ready drops
	localparam int LONG_HOLD = 120;
	// settling margin after the last result, waited out before a size write and at the end
	localparam int SETTLE_CYCLES = 8;
	// longest correct quiet stretch is the long hold-off plus a drain; allow far more
	localparam int QUIET_LIMIT = 4000;
	localparam win_size_t SIZE_MIN = 3'd1;
	localparam win_size_t SIZE_MID = 3'd5;
	localparam win_size_t SIZE_MAX = 3'd7;

	typedef row_t [ROW_PIX-1:0] window_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	win_size_t cfg_wdata;

	wms_win_if win ();
	wms_res_if res ();

	int unsigned fail_count;
	int unsigned in_flight;

	// stimulus-side controls for source gaps and the result sink
	int unsigned hold_requests;
	logic src_gaps;
	logic sink_stalls;

	int unsigned windows_sent;
	int unsigned size_writes;

	window_median_select_core #(
		.MAX_WINDOW(MAX_WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pixels(win),
		.result(res)
	);

	wms_median_checker #(
		.MAX_WINDOW(MAX_WINDOW)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.win(win),
		.res(res),
		.fail_count(fail_count),
		.in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Window builders

	// Used k by k corner set to one value, the rest of the 7x7 grid to another:
	// any leak of unused pixels into the ranking shows up at once.
	function automatic window_t fill_window(input pixel_t used, input pixel_t unused,
			input win_size_t k);
		window_t w;
		for (int r = 0; r < ROW_PIX; r++)
			for (int c = 0; c < ROW_PIX; c++)
				w[r][c*PIX_W +: PIX_W] = (r < int'(k) && c < int'(k)) ? used : unused;
		return w;
	endfunction

	// Strictly falling pixels in scan order, so the median only comes out if sorted.
	function automatic window_t ramp_window();
		window_t w;
		for (int r = 0; r < ROW_PIX; r++)
			for (int c = 0; c < ROW_PIX; c++)
				w[r][c*PIX_W +: PIX_W] = pixel_t'(252 - 5 * (r * ROW_PIX + c));
		return w;
	endfunction

	// Mix of fully random pixels, heavy ties, black/white only and a flat
	// background with a few outliers (the usual impulse-noise case).
	function automatic window_t random_window();
		window_t w;
		int unsigned mode;
		int unsigned base;
		mode = $urandom_range(0, 3);
		base = $urandom_range(0, 255);
		for (int r = 0; r < ROW_PIX; r++)
			for (int c = 0; c < ROW_PIX; c++)
				case (mode)
					0: w[r][c*PIX_W +: PIX_W] = pixel_t'($urandom);
					1: w[r][c*PIX_W +: PIX_W] = pixel_t'(base + $urandom_range(0, 3));
					2: w[r][c*PIX_W +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					default: begin
						w[r][c*PIX_W +: PIX_W] =
							($urandom_range(0, 9) == 0) ? pixel_t'($urandom) : pixel_t'(base);
					end
				endcase
		return w;
	endfunction

	// Window channel driving

	// Offer one window beat and hold it until accepted. Valid is left high so that
	// back-to-back beats need no extra edge.
	task automatic send_window(input window_t w);
		win.valid <= 1'b1;
		win.window_row_0 <= w[0];
		win.window_row_1 <= w[1];
		win.window_row_2 <= w[2];
		win.window_row_3 <= w[3];
		win.window_row_4 <= w[4];
		win.window_row_5 <= w[5];
		win.window_row_6 <= w[6];
		do
			@(posedge clk);
		while (!win.ready);
		windows_sent++;
	endtask

	// Occasionally drop valid for a random burst after a beat.
	task automatic source_gap();
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			win.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected result beat has come back,
	// then let the pipeline settle. The first edge lets the checker count a beat
	// accepted at the edge this task was entered on.
	task automatic drain_results();
		win.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write window_size only with nothing in flight.
	task automatic set_window_size(input win_size_t k);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_writes++;
	endtask

	// Result sink: random stall bursts while enabled, plus a long hold-off
	// whenever the stimulus asks for one. Exactly one assignment to ready per edge.
	initial begin : result_sink
		int unsigned low_left;
		int unsigned holds_done;
		low_left = 0;
		holds_done = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				low_left = LONG_HOLD;
			end else if (low_left == 0 && sink_stalls && $urandom_range(0, 7) == 0) begin
				low_left = $urandom_range(1, 18);
			end
			if (low_left != 0) begin
				res.ready <= 1'b0;
				low_left--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((win.valid && win.ready) || (res.valid && res.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
		$display("window_median_select_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_done;
		int unsigned chunk;
		int unsigned chunk_no;
		int unsigned remaining;
		logic calm;
		logic want_hold;
		win_size_t k;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= WIN_SIZE_RESET;
		win.valid <= 1'b0;
		win.window_row_0 <= '0;
		win.window_row_1 <= '0;
		win.window_row_2 <= '0;
		win.window_row_3 <= '0;
		win.window_row_4 <= '0;
		win.window_row_5 <= '0;
		win.window_row_6 <= '0;
		src_gaps <= 1'b0;
		sink_stalls <= 1'b0;
		hold_requests <= 0;
		windows_sent = 0;
		size_writes = 0;

		// hold reset, then release it on an edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset size (3) first: unused pixels at the opposite
		// extreme, all-max used pixels, a falling ramp and alternating bit patterns.
		send_window(fill_window(8'h00, 8'hFF, WIN_SIZE_RESET));
		send_window(fill_window(8'hFF, 8'h00, WIN_SIZE_RESET));
		send_window(ramp_window());
		send_window({ROW_PIX{56'hAA55AA55AA55AA}});
		send_window({ROW_PIX{56'h55AA55AA55AA55}});

		// smallest window: the median is pixel 0 of row 0
		set_window_size(SIZE_MIN);
		send_window(fill_window(8'h5A, 8'hFF, SIZE_MIN));
		send_window(ramp_window());
		send_window(random_window());

		// full 7x7 window
		set_window_size(SIZE_MAX);
		send_window({ROW_PIX{56'hFFFFFFFFFFFFFF}});
		send_window('0);
		send_window(ramp_window());
		send_window(random_window());

		// every even size must flag an error and return zero
		for (int e = 0; e < 8; e += 2) begin
			set_window_size(win_size_t'(e));
			send_window(random_window());
		end

		set_window_size(SIZE_MID);
		send_window(fill_window(8'h80, 8'h00, SIZE_MID));
		send_window(random_window());

		// Random part: chunks of windows, each with its own size and idling mix.
		// Mostly odd sizes; the odd even size keeps the error path busy.
		random_done = 0;
		chunk_no = 0;
		while (random_done < RANDOM_WINDOWS) begin
			if ($urandom_range(0, 5) == 0)
				k = win_size_t'(2 * $urandom_range(0, 3));
			else
				k = win_size_t'(2 * $urandom_range(0, 3) + 1);
			set_window_size(k);

			remaining = RANDOM_WINDOWS - random_done;
			calm = (remaining <= CALM_TAIL);
			if (calm)
				chunk = remaining;
			else
				chunk = $urandom_range(40, 160);
			if (!calm && chunk > remaining - CALM_TAIL)
				chunk = remaining - CALM_TAIL;

			// one early chunk: long hold-off on the result side while the source
			// keeps offering back to back, so the pipeline fills and stalls input
			want_hold = (chunk_no == 2);
			if (want_hold)
				hold_requests <= hold_requests + 1;
			src_gaps <= !calm && !want_hold && ($urandom_range(0, 3) != 0);
			sink_stalls <= !calm && ($urandom_range(0, 3) != 0);

			for (int i = 0; i < chunk; i++) begin
				send_window(random_window());
				random_done++;
				source_gap();
			end
			chunk_no++;
		end

		drain_results();

		$display("Covered %0d windows over %0d window size writes: sizes 1 to 7, even sizes,",
			windows_sent, size_writes);
		$display("unused-pixel extremes, random stalls and a %0d-cycle result hold-off.",
			LONG_HOLD);
		if (fail_count == 0 && in_flight == 0) begin
			$display("window_median_select_core regression: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", fail_count, in_flight);
			$display("window_median_select_core regression: fail");
		end
		$finish;
	end

endmodule
